// ===== hw/rtl/symmetric_polar_sparse_row_offset_assert.svh =====
// Assertion macros used by the checker of the polar row-offset block.
`ifndef SYMMETRIC_POLAR_SPARSE_ROW_OFFSET_ASSERT_SVH
`define SYMMETRIC_POLAR_SPARSE_ROW_OFFSET_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define SPSRO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define SPSRO_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/spsro_pkg.sv =====
// Types, codes and helpers shared by the polar row-offset pipeline.
`default_nettype none
package spsro_pkg;

    localparam int unsigned CFG_W = 13;
    localparam int unsigned IDX_W = 12;
    localparam int unsigned OUT_W = 28;
    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_NODES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_NODES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIRICHLET = 3'd4;

    localparam logic [CFG_W-1:0] RST_RADIAL_NODES   = 13'd4;
    localparam logic [CFG_W-1:0] RST_ANGULAR_NODES  = 13'd8;
    localparam logic [CFG_W-1:0] RST_CIRCLE_COUNT   = 13'd2;
    localparam logic [CFG_W-1:0] RST_RADIAL_LENGTH  = 13'd2;

    // Per-angle non-zeros are 9*nr plus this offset (Dirichlet or across origin).
    localparam logic [OUT_W-1:0] TOTAL_ADJ_DIR    = 28'(-22);
    localparam logic [OUT_W-1:0] TOTAL_ADJ_ORIGIN = 28'(-13);
    localparam logic [OUT_W-1:0] OUTER_EXTRA      = 28'd6;

    typedef enum logic [2:0] {
        KIND_INTERIOR   = 3'd0,
        KIND_BOUNDARY   = 3'd1,
        KIND_ACROSS     = 3'd2,
        KIND_NEXT_INNER = 3'd3,
        KIND_NEXT_OUTER = 3'd4
    } kind_t;

    // Which layout section holds the row.
    typedef enum logic [2:0] {
        OFS_CIRCLE     = 3'd0,
        OFS_RADIAL     = 3'd1,
        OFS_INNER      = 3'd2,
        OFS_NEXT_INNER = 3'd3,
        OFS_NEXT_OUTER = 3'd4,
        OFS_OUTER      = 3'd5
    } ofs_t;

    typedef struct packed {
        logic [CFG_W-1:0] radial_nodes;
        logic [CFG_W-1:0] angular_nodes;
        logic [CFG_W-1:0] circle_section_count;
        logic [CFG_W-1:0] radial_section_length;
        logic             inner_dirichlet;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] radius_index;
        logic [IDX_W-1:0] angle_index;
    } in_t;

    typedef struct packed {
        logic [OUT_W-1:0] row_offset;
        logic [OUT_W-1:0] nonzero_total;
        logic [2:0]       stencil_kind;
        logic             index_invalid;
    } out_t;

    typedef struct packed {
        logic [IDX_W-1:0]   t;
        logic signed [13:0] rm2;
        logic signed [13:0] rlm2;
        logic signed [13:0] csm2;
        logic signed [13:0] r_m_cs;
        logic [OUT_W-1:0]   scale;
        kind_t              kind;
        logic               invalid;
        ofs_t               ofs;
    } dec_t;

    typedef struct packed {
        logic [OUT_W-1:0]   p_a;
        logic [OUT_W-1:0]   p_b;
        logic [OUT_W-1:0]   p_c;
        logic [OUT_W-1:0]   p_tot;
        logic [OUT_W-1:0]   base;
        logic [OUT_W-1:0]   cin_t;
        logic [OUT_W-1:0]   cnin_t;
        logic [OUT_W-1:0]   cin_nt;
        logic [IDX_W-1:0]   t;
        logic signed [13:0] rlm2;
        logic signed [13:0] r_m_cs;
        kind_t              kind;
        logic               invalid;
        ofs_t               ofs;
    } mul_t;

    typedef struct packed {
        logic [OUT_W-1:0] pre;
        logic [OUT_W-1:0] d;
        logic [OUT_W-1:0] add;
        logic [OUT_W-1:0] total;
        kind_t            kind;
        logic             invalid;
    } part_t;

    function automatic logic [OUT_W-1:0] sx14(input logic signed [13:0] v);
        return OUT_W'(v);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/spsro_decode.sv =====
// First stage: stencil kind, layout section and narrow differences.
`default_nettype none
module spsro_decode (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire spsro_pkg::cfg_t cfg,
    input  wire logic            up_valid,
    output logic                 up_ready,
    input  wire spsro_pkg::in_t  up_data,
    output logic                 dn_valid,
    input  wire logic            dn_ready,
    output spsro_pkg::dec_t      dn_data
);

    logic            vld_reg;
    spsro_pkg::dec_t data_reg;
    spsro_pkg::dec_t data_next;

    logic signed [14:0] r_s;
    logic signed [14:0] nr_m1;
    logic signed [14:0] nr_m2;
    logic signed [14:0] cs_s;
    logic               dir;
    logic               r_is0;
    logic               r_is1;
    logic               lt_nr2;
    logic [spsro_pkg::OUT_W-1:0] nr28;

    always_comb
    begin
        r_s    = $signed({3'b0, up_data.radius_index});
        nr_m1  = $signed({2'b0, cfg.radial_nodes}) - 15'sd1;
        nr_m2  = $signed({2'b0, cfg.radial_nodes}) - 15'sd2;
        cs_s   = $signed({2'b0, cfg.circle_section_count});
        dir    = cfg.inner_dirichlet;
        r_is0  = (r_s == 15'sd0);
        r_is1  = (r_s == 15'sd1);
        lt_nr2 = (r_s < nr_m2);
        nr28   = {15'b0, cfg.radial_nodes};

        data_next.t       = up_data.angle_index;
        data_next.rm2     = $signed({2'b0, up_data.radius_index}) - 14'sd2;
        data_next.rlm2    = $signed({1'b0, cfg.radial_section_length}) - 14'sd2;
        data_next.csm2    = $signed({1'b0, cfg.circle_section_count}) - 14'sd2;
        data_next.r_m_cs  = $signed({2'b0, up_data.radius_index})
                          - $signed({1'b0, cfg.circle_section_count});
        data_next.scale   = (nr28 << 3) + nr28
                          + (dir ? spsro_pkg::TOTAL_ADJ_DIR : spsro_pkg::TOTAL_ADJ_ORIGIN);
        data_next.invalid = 1'b0;

        if ((r_s > 15'sd1 && lt_nr2) || (r_is1 && !dir))
            data_next.kind = spsro_pkg::KIND_INTERIOR;
        else if (r_s == nr_m1 || (r_is0 && dir))
            data_next.kind = spsro_pkg::KIND_BOUNDARY;
        else if (r_is0)
            data_next.kind = spsro_pkg::KIND_ACROSS;
        else if (r_is1)
            data_next.kind = spsro_pkg::KIND_NEXT_INNER;
        else if (r_s == nr_m2)
            data_next.kind = spsro_pkg::KIND_NEXT_OUTER;
        else
        begin
            data_next.kind    = spsro_pkg::KIND_INTERIOR;
            data_next.invalid = 1'b1;
        end

        // The section checks keep their own order; a radial-section match can
        // take the innermost circles when the circle section is short.
        if (r_s > 15'sd1 && r_s < cs_s)
            data_next.ofs = spsro_pkg::OFS_CIRCLE;
        else if (cs_s <= r_s && lt_nr2)
            data_next.ofs = spsro_pkg::OFS_RADIAL;
        else if (r_is0)
            data_next.ofs = spsro_pkg::OFS_INNER;
        else if (r_is1)
            data_next.ofs = spsro_pkg::OFS_NEXT_INNER;
        else if (r_s == nr_m2)
            data_next.ofs = spsro_pkg::OFS_NEXT_OUTER;
        else
            data_next.ofs = spsro_pkg::OFS_OUTER;
    end

    assign up_ready = !vld_reg || dn_ready;
    assign dn_valid = vld_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (up_ready)
            vld_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/spsro_mult.sv =====
// Second stage: the four products and the small constant-scaled terms.
`default_nettype none
module spsro_mult (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire spsro_pkg::cfg_t cfg,
    input  wire logic            up_valid,
    output logic                 up_ready,
    input  wire spsro_pkg::dec_t up_data,
    output logic                 dn_valid,
    input  wire logic            dn_ready,
    output spsro_pkg::mul_t      dn_data
);

    logic            vld_reg;
    spsro_pkg::mul_t data_reg;
    spsro_pkg::mul_t data_next;

    logic [spsro_pkg::OUT_W-1:0] nt28;
    logic [spsro_pkg::OUT_W-1:0] t28;
    logic                        dir;

    always_comb
    begin
        nt28 = {15'b0, cfg.angular_nodes};
        t28  = {16'b0, up_data.t};
        dir  = cfg.inner_dirichlet;

        // All products wrap to the output width, which is exact modulo 2^28.
        data_next.p_a    = spsro_pkg::sx14(up_data.rm2) * nt28;
        data_next.p_b    = t28 * spsro_pkg::sx14(up_data.rlm2);
        data_next.p_c    = nt28 * spsro_pkg::sx14(up_data.csm2);
        data_next.p_tot  = up_data.scale * nt28;
        data_next.base   = dir ? (nt28 << 3) - nt28 : (nt28 << 4);
        data_next.cin_t  = dir ? t28 : (t28 << 3) - t28;
        data_next.cnin_t = dir ? (t28 << 2) + (t28 << 1) : (t28 << 3) + t28;
        data_next.cin_nt = dir ? nt28 : (nt28 << 3) - nt28;
        data_next.t       = up_data.t;
        data_next.rlm2    = up_data.rlm2;
        data_next.r_m_cs  = up_data.r_m_cs;
        data_next.kind    = up_data.kind;
        data_next.invalid = up_data.invalid;
        data_next.ofs     = up_data.ofs;
    end

    assign up_ready = !vld_reg || dn_ready;
    assign dn_valid = vld_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (up_ready)
            vld_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/spsro_partial.sv =====
// Third stage: per-section partial sums, reduced to pre + 9*d + add.
`default_nettype none
module spsro_partial (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            up_valid,
    output logic                 up_ready,
    input  wire spsro_pkg::mul_t up_data,
    output logic                 dn_valid,
    input  wire logic            dn_ready,
    output spsro_pkg::part_t     dn_data
);

    logic             vld_reg;
    spsro_pkg::part_t data_reg;
    spsro_pkg::part_t data_next;

    logic [spsro_pkg::OUT_W-1:0] t28;
    logic [spsro_pkg::OUT_W-1:0] seven_t;
    logic [spsro_pkg::OUT_W-1:0] circ_base;
    logic [spsro_pkg::OUT_W-1:0] d_outer;

    always_comb
    begin
        t28       = {16'b0, up_data.t};
        seven_t   = (t28 << 3) - t28;
        circ_base = up_data.base + (up_data.p_c << 3) + up_data.p_c;
        // (t + 1) * (rl - 2) is t * (rl - 2) plus rl - 2.
        d_outer   = up_data.p_b + spsro_pkg::sx14(up_data.rlm2);

        data_next.total   = up_data.p_tot;
        data_next.kind    = up_data.kind;
        data_next.invalid = up_data.invalid;
        data_next.pre     = '0;
        data_next.d       = '0;
        data_next.add     = '0;

        if (!up_data.invalid)
        begin
            case (up_data.ofs)
                spsro_pkg::OFS_CIRCLE:
                begin
                    data_next.pre = up_data.base;
                    data_next.d   = up_data.p_a + t28;
                end
                spsro_pkg::OFS_RADIAL:
                begin
                    data_next.pre = circ_base;
                    data_next.d   = up_data.p_b + spsro_pkg::sx14(up_data.r_m_cs);
                    data_next.add = seven_t;
                end
                spsro_pkg::OFS_INNER:
                begin
                    data_next.pre = up_data.cin_t;
                end
                spsro_pkg::OFS_NEXT_INNER:
                begin
                    data_next.pre = up_data.cin_nt;
                    data_next.add = up_data.cnin_t;
                end
                spsro_pkg::OFS_NEXT_OUTER:
                begin
                    data_next.pre = circ_base;
                    data_next.d   = d_outer;
                    data_next.add = seven_t;
                end
                default:
                begin
                    data_next.pre = circ_base;
                    data_next.d   = d_outer;
                    data_next.add = seven_t + spsro_pkg::OUTER_EXTRA;
                end
            endcase
        end
    end

    assign up_ready = !vld_reg || dn_ready;
    assign dn_valid = vld_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (up_ready)
            vld_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/spsro_final.sv =====
// Last stage: final row-offset sum into the output register.
`default_nettype none
module spsro_final (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             up_valid,
    output logic                  up_ready,
    input  wire spsro_pkg::part_t up_data,
    output logic                  dn_valid,
    input  wire logic             dn_ready,
    output spsro_pkg::out_t       dn_data
);

    logic            vld_reg;
    spsro_pkg::out_t data_reg;
    spsro_pkg::out_t data_next;

    always_comb
    begin
        data_next.row_offset    = up_data.pre + (up_data.d << 3) + up_data.d + up_data.add;
        data_next.nonzero_total = up_data.total;
        data_next.stencil_kind  = up_data.kind;
        data_next.index_invalid = up_data.invalid;
    end

    assign up_ready = !vld_reg || dn_ready;
    assign dn_valid = vld_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (up_ready)
            vld_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/symmetric_polar_sparse_row_offset.sv =====
// An accepted input is registered in turn by the decode, multiply, partial-sum
// and final-sum stages before out_valid rises for it.
// Throughput: one item per cycle through these four register stages; a stall
// holds every full stage in place, while an empty stage can still take an item.
// Reset (rst_n low, asynchronous) empties all stages and loads the registers
// with nr = 4, ntheta = 8, circle count 2, radial length 2, across-origin mode.
`default_nettype none
module symmetric_polar_sparse_row_offset (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [spsro_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [spsro_pkg::CFG_W-1:0]         cfg_wr_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire spsro_pkg::in_t                      in_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output spsro_pkg::out_t                          out_data
);

    spsro_pkg::cfg_t cfg_reg;

    logic             dec_valid;
    logic             dec_ready;
    spsro_pkg::dec_t  dec_data;
    logic             mul_valid;
    logic             mul_ready;
    spsro_pkg::mul_t  mul_data;
    logic             part_valid;
    logic             part_ready;
    spsro_pkg::part_t part_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radial_nodes          <= spsro_pkg::RST_RADIAL_NODES;
            cfg_reg.angular_nodes         <= spsro_pkg::RST_ANGULAR_NODES;
            cfg_reg.circle_section_count  <= spsro_pkg::RST_CIRCLE_COUNT;
            cfg_reg.radial_section_length <= spsro_pkg::RST_RADIAL_LENGTH;
            cfg_reg.inner_dirichlet       <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                spsro_pkg::REG_RADIAL_NODES:    cfg_reg.radial_nodes          <= cfg_wr_data;
                spsro_pkg::REG_ANGULAR_NODES:   cfg_reg.angular_nodes         <= cfg_wr_data;
                spsro_pkg::REG_CIRCLE_COUNT:    cfg_reg.circle_section_count  <= cfg_wr_data;
                spsro_pkg::REG_RADIAL_LENGTH:   cfg_reg.radial_section_length <= cfg_wr_data;
                spsro_pkg::REG_INNER_DIRICHLET: cfg_reg.inner_dirichlet       <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    spsro_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .up_data  (in_data),
        .dn_valid (dec_valid),
        .dn_ready (dec_ready),
        .dn_data  (dec_data)
    );

    spsro_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (dec_valid),
        .up_ready (dec_ready),
        .up_data  (dec_data),
        .dn_valid (mul_valid),
        .dn_ready (mul_ready),
        .dn_data  (mul_data)
    );

    spsro_partial u_partial (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mul_valid),
        .up_ready (mul_ready),
        .up_data  (mul_data),
        .dn_valid (part_valid),
        .dn_ready (part_ready),
        .dn_data  (part_data)
    );

    spsro_final u_final (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (part_valid),
        .up_ready (part_ready),
        .up_data  (part_data),
        .dn_valid (out_valid),
        .dn_ready (out_ready),
        .dn_data  (out_data)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/spsro_checker.sv =====
// Port-level checker for the polar row-offset block, bound to the top level.
`default_nettype none
`include "symmetric_polar_sparse_row_offset_assert.svh"
module spsro_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_ready,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire spsro_pkg::out_t out_data
);

    // An invalid index must come out with a zero offset and the interior code.
    `SPSRO_ASSERT_NOW(a_invalid_zero, out_valid && out_data.index_invalid, out_data.row_offset == 28'd0 && out_data.stencil_kind == spsro_pkg::KIND_INTERIOR, "invalid index with nonzero offset or kind")

    // With the output stage empty every stage can move, so input is taken.
    `SPSRO_ASSERT_NOW(a_empty_ready, !out_valid, in_ready, "input stalled while output stage empty")

    // A result that is not taken stays and does not change.
    `SPSRO_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result dropped or changed")

    // Known stencil codes only.
    `SPSRO_ASSERT_NOW(a_kind_range, out_valid, out_data.stencil_kind <= spsro_pkg::KIND_NEXT_OUTER, "stencil kind out of range")

endmodule

bind symmetric_polar_sparse_row_offset spsro_checker u_spsro_checker (.*);
`default_nettype wire
